>>> hw/rtl/bfd_pkg.sv
package bfd_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int LENGTH_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

  localparam logic [LENGTH_BITS-1:0] CAP_RESET = '1;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] item_length;
    logic                   last_item;
  } in_word_t;

  typedef struct packed {
    logic [5:0] bin_number;
    logic [5:0] item_number;
    logic       error;
    logic       last_result;
  } out_word_t;

  // one entry of the sorted item chain
  typedef struct packed {
    logic                   valid;
    logic [LENGTH_BITS-1:0] len;
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       bin;
  } sort_ent_t;

  typedef struct packed {
    logic ins;
    logic rot;
    logic clr;
  } sort_ctl_t;

  // one entry of the bin chain
  typedef struct packed {
    logic                   valid;
    logic [LENGTH_BITS-1:0] rem;
  } bin_ent_t;

  typedef struct packed {
    logic                   rot;
    logic                   sub;
    logic                   open;
    logic                   clr;
    logic [IDX_W-1:0]       sel;
    logic [LENGTH_BITS-1:0] amount;
  } bin_ctl_t;

endpackage

>>> hw/rtl/best_fit_decreasing_bin_packer.sv
// Best-fit-decreasing bin packer. Lengths load one word per cycle into a
// chain of 64 sort cells that keeps them ordered longest first as they
// arrive. After the last word, each item in that order is placed in turn:
// the 64-cell bin chain rotates once past a comparator to find the tightest
// bin, then the update state changes that bin or opens a new one. Results
// then leave by bin, one full rotation of the sort chain per bin used; the
// rotation holds while a result waits for output space. A rejected set
// gives its single error word right after loading. New input is taken only
// while loading.
module best_fit_decreasing_bin_packer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bfd_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bfd_pkg::out_word_t         out_data,
  input  logic                       cfg_we,
  input  logic [bfd_pkg::LENGTH_BITS-1:0] cfg_wdata
);
  import bfd_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_ERR   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LENGTH_BITS-1:0] cap_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [IDX_W-1:0]       scan_r, scan_nxt;
  logic [CNT_W-1:0]       place_r, place_nxt;
  logic [CNT_W-1:0]       nbins_r, nbins_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       best_r, best_nxt;
  logic [LENGTH_BITS-1:0] best_rem_r, best_rem_nxt;
  logic [IDX_W-1:0]       ecnt_r, ecnt_nxt;
  logic [IDX_W-1:0]       bcur_r, bcur_nxt;
  logic [CNT_W-1:0]       done_r, done_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  sort_ent_t sc   [MAX_ITEMS];
  logic      ins  [MAX_ITEMS];
  bin_ent_t  bc   [MAX_ITEMS];
  sort_ctl_t sctl;
  bin_ctl_t  bctl;
  sort_ent_t new_item, tail_in;

  logic                   in_fire, out_free, emit_hit, fits;
  logic [IDX_W-1:0]       assign_bin;

  assign in_ready  = (state_r == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_item.valid = 1'b1;
  assign new_item.len   = in_data.item_length;
  assign new_item.idx   = count_r[IDX_W-1:0];
  assign new_item.bin   = '0;

  assign assign_bin = found_r ? best_r : nbins_r[IDX_W-1:0];
  assign fits = bc[0].valid && (bc[0].rem >= sc[0].len) &&
                (!found_r || (bc[0].rem < best_rem_r));
  assign emit_hit = sc[0].valid && (sc[0].bin == bcur_r);

  // head wraps to the tail, tagged with its bin at placement
  always_comb begin
    tail_in = sc[0];
    if (state_r == S_UPD) begin
      tail_in.bin = assign_bin;
    end
  end

  // sort chain
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_sort
    bfd_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (sctl),
      .new_item  (new_item),
      .prev_item ((k == 0) ? sc[0] : sc[(k == 0) ? 0 : k - 1]),
      .next_item ((k == MAX_ITEMS - 1) ? tail_in : sc[(k + 1) % MAX_ITEMS]),
      .prev_ins  ((k == 0) ? 1'b0 : ins[(k == 0) ? 0 : k - 1]),
      .cur       (sc[k]),
      .ins       (ins[k])
    );
  end

  // bin chain
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_bin
    bfd_bin_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .own_idx  (IDX_W'(k)),
      .ctl      (bctl),
      .next_bin (bc[(k + 1) % MAX_ITEMS]),
      .cur      (bc[k])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    scan_nxt      = scan_r;
    place_nxt     = place_r;
    nbins_nxt     = nbins_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_rem_nxt  = best_rem_r;
    ecnt_nxt      = ecnt_r;
    bcur_nxt      = bcur_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    sctl          = '0;
    bctl          = '0;
    bctl.sel      = assign_bin;
    bctl.amount   = found_r ? sc[0].len : cap_r - sc[0].len;

    case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            sctl.ins  = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        scan_nxt  = '0;
        place_nxt = '0;
        nbins_nxt = '0;
        found_nxt = 1'b0;
        if (ovf_r || (cap_r == '0) || (sc[0].len > cap_r)) begin
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.error       = 1'b1;
          out_data_nxt.last_result = 1'b1;
          state_nxt                = S_CLEAR;
        end
      end
      S_SCAN: begin
        // track tightest fitting bin; strict compare keeps lowest number
        bctl.rot = 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (fits) begin
          found_nxt    = 1'b1;
          best_nxt     = scan_r;
          best_rem_nxt = bc[0].rem;
        end
        if (scan_r == IDX_W'(MAX_ITEMS - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        bctl.sub  = found_r;
        bctl.open = !found_r;
        sctl.rot  = 1'b1;
        if (!found_r) begin
          nbins_nxt = nbins_r + 1'b1;
        end
        place_nxt = place_r + 1'b1;
        found_nxt = 1'b0;
        scan_nxt  = '0;
        ecnt_nxt  = '0;
        bcur_nxt  = '0;
        done_nxt  = '0;
        if (place_r + 1'b1 == count_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_EMIT: begin
        // hold the chain while a matching word waits for output space
        if (!emit_hit || out_free) begin
          sctl.rot = 1'b1;
          ecnt_nxt = ecnt_r + 1'b1;
          if (emit_hit) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.bin_number  = bcur_r;
            out_data_nxt.item_number = sc[0].idx;
            out_data_nxt.error       = 1'b0;
            out_data_nxt.last_result = (done_r + 1'b1 == count_r);
            done_nxt                 = done_r + 1'b1;
          end
          if (ecnt_r == IDX_W'(MAX_ITEMS - 1)) begin
            bcur_nxt = bcur_r + 1'b1;
            if (CNT_W'(bcur_r) + 1'b1 == nbins_r) begin
              state_nxt = S_CLEAR;
            end
          end
        end
      end
      S_CLEAR: begin
        sctl.clr  = 1'b1;
        bctl.clr  = 1'b1;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      scan_r      <= '0;
      place_r     <= '0;
      nbins_r     <= '0;
      ecnt_r      <= '0;
      bcur_r      <= '0;
      done_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      scan_r      <= scan_nxt;
      place_r     <= place_nxt;
      nbins_r     <= nbins_nxt;
      ecnt_r      <= ecnt_nxt;
      bcur_r      <= bcur_nxt;
      done_r      <= done_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_rem_r <= best_rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hw/rtl/bfd_sort_cell.sv
module bfd_sort_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bfd_pkg::sort_ctl_t ctl,
  input  bfd_pkg::sort_ent_t new_item,
  input  bfd_pkg::sort_ent_t prev_item,
  input  bfd_pkg::sort_ent_t next_item,
  input  logic              prev_ins,
  output bfd_pkg::sort_ent_t cur,
  output logic              ins
);
  import bfd_pkg::*;

  sort_ent_t cur_r;

  // new item goes before this entry (equal length: later load index first)
  assign ins = !cur_r.valid || (new_item.len >= cur_r.len);
  assign cur = cur_r;

  // insert, rotate toward the head, or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (ctl.clr) begin
      cur_r.valid <= 1'b0;
    end else if (ctl.rot) begin
      cur_r <= next_item;
    end else if (ctl.ins && ins) begin
      cur_r <= prev_ins ? prev_item : new_item;
    end
  end

endmodule

>>> hw/rtl/bfd_bin_cell.sv
module bfd_bin_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bfd_pkg::IDX_W-1:0]   own_idx,
  input  bfd_pkg::bin_ctl_t           ctl,
  input  bfd_pkg::bin_ent_t           next_bin,
  output bfd_pkg::bin_ent_t           cur
);
  import bfd_pkg::*;

  bin_ent_t cur_r;

  assign cur = cur_r;

  // rotate during the scan; at home position take or open a bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
    end else if (ctl.clr) begin
      cur_r.valid <= 1'b0;
    end else if (ctl.rot) begin
      cur_r <= next_bin;
    end else if (ctl.sub && (ctl.sel == own_idx)) begin
      cur_r.rem <= cur_r.rem - ctl.amount;
    end else if (ctl.open && (ctl.sel == own_idx)) begin
      cur_r.rem   <= ctl.amount;
      cur_r.valid <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/bfd_checker.sv
module bfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bfd_pkg::out_word_t out_data
);
  import bfd_pkg::*;

  // offered input word stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn before acceptance");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // error word is a lone final word with zero fields
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      out_data.last_result && (out_data.bin_number == '0) &&
      (out_data.item_number == '0))
    else $error("malformed error word");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind best_fit_decreasing_bin_packer bfd_checker u_bfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> bench/best_fit_decreasing_bin_packer_tb.sv
`timescale 1ns / 100ps

module best_fit_decreasing_bin_packer_tb;
  import bfd_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [LENGTH_BITS-1:0] cfg_wdata = '0;

  best_fit_decreasing_bin_packer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] capacity_q;
  logic [15:0] held_len[MAX_ITEMS];
  int          held_count;
  bit          set_overflow;
  out_word_t   placement_q[$];

  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int sets_done = 0;
  int error_sets = 0;
  bit stim_done = 1'b0;

  function automatic bit packs_first(int a, int b);
    if (held_len[a] != held_len[b]) return held_len[a] > held_len[b];
    return a > b;
  endfunction

  // model one accepted input word; queue the placements it yields
  task automatic predict_word(input logic [15:0] len, input bit last);
    int order[MAX_ITEMS];
    logic [15:0] rem[MAX_ITEMS];
    int where[MAX_ITEMS];
    int n, nbins, pick, v, j, placed;
    bit bad;
    out_word_t w;
    if (held_count < MAX_ITEMS) begin
      held_len[held_count] = len;
      held_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return;
    n = held_count;
    bad = set_overflow || (capacity_q == 0);
    for (int i = 0; i < n; i++) if (held_len[i] > capacity_q) bad = 1'b1;
    held_count = 0;
    set_overflow = 1'b0;
    sets_done++;
    if (bad) begin
      error_sets++;
      w = '0; w.error = 1'b1; w.last_result = 1'b1;
      placement_q = {placement_q, w};
      return;
    end
    // insertion sort, longest first
    for (int i = 0; i < n; i++) begin
      v = i; j = i;
      while (j > 0 && packs_first(v, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    nbins = 0;
    for (int p = 0; p < n; p++) begin
      pick = -1;
      for (int b = 0; b < nbins; b++)
        if (rem[b] >= held_len[order[p]] && (pick < 0 || rem[b] < rem[pick])) pick = b;
      if (pick >= 0) begin
        rem[pick] -= held_len[order[p]];
        where[order[p]] = pick;
      end else begin
        rem[nbins] = capacity_q - held_len[order[p]];
        where[order[p]] = nbins;
        nbins++;
      end
    end
    placed = 0;
    for (int b = 0; b < nbins; b++)
      for (int p = 0; p < n; p++)
        if (where[order[p]] == b) begin
          placed++;
          w.bin_number = b[5:0];
          w.item_number = order[p][5:0];
          w.error = 1'b0;
          w.last_result = (placed == n);
          placement_q = {placement_q, w};
        end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (placement_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== placement_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, placement_q[0], out_data);
          errors++;
        end
        void'(placement_q.pop_front());
      end
    end
  end

  // randomly stall the result side
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // offer one word; valid stays up afterward unless a gap follows
  task automatic send_word(input logic [15:0] len, input bit last);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= '{item_length: len, last_item: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(len, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    // the block may still be clearing its chains after the last word
    repeat (9000) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_q = value;
  endtask

  task automatic send_set(input int n, input int mode);
    logic [15:0] len;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: len = 16'($urandom_range(0, capacity_q));
        1: len = 16'($urandom_range(0, capacity_q / 3));
        2: len = 16'($urandom_range(0, 3) * (capacity_q / 4));
        default: len = 16'($urandom());
      endcase
      send_word(len, i == n - 1);
    end
  endtask

  // directed rows: length, last flag
  typedef struct {
    logic [15:0] len;
    bit          last;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{16'hFFFF, 1'b1},
    '{16'h0000, 1'b1},
    '{16'h0000, 1'b0}, '{16'hFFFF, 1'b0}, '{16'h8000, 1'b0}, '{16'h7FFF, 1'b1},
    '{16'h5555, 1'b0}, '{16'hAAAA, 1'b0}, '{16'h5555, 1'b0}, '{16'h5555, 1'b1},
    '{16'h0001, 1'b0}, '{16'h0001, 1'b0}, '{16'h0001, 1'b1}
  };

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    capacity_q = CAP_RESET;
    held_count = 0;
    set_overflow = 1'b0;
    @(negedge clk);

    // directed: reset capacity, extremes and equal lengths
    foreach (directed_rows[i]) send_word(directed_rows[i].len, directed_rows[i].last);
    drain_results();

    // a single over-long item must give exactly the error word
    write_capacity(16'd100);
    send_word(16'd101, 1'b1);
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    @(negedge clk);
    if (errors == 0 && words_seen == 0) errors++;
    send_word(16'd100, 1'b0);
    send_word(16'd0, 1'b1);
    drain_results();

    // smallest capacity and the zero capacity reject
    write_capacity(16'd1);
    send_word(16'd1, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd0, 1'b1);
    drain_results();
    write_capacity(16'd0);
    send_word(16'd0, 1'b1);
    drain_results();

    // too many items: 65 words overflow, then a full set of 64
    write_capacity(16'hFFFF);
    send_set(65, 3);
    send_set(MAX_ITEMS, 3);
    drain_results();

    // random sets under several capacities
    while (words_sent < 460) begin
      case ($urandom_range(0, 4))
        0: write_capacity(16'hFFFF);
        1: write_capacity(16'd1);
        2: write_capacity(16'($urandom_range(2, 64)));
        default: write_capacity(16'($urandom()));
      endcase
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) send_set($urandom_range(1, 12), 3);
        else send_set($urandom_range(1, 16), $urandom_range(0, 2));
      end
      drain_results();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Sent %0d words in %0d sets (%0d rejected), checked %0d results.",
             words_sent, sets_done, error_sets, words_seen);
    if (errors == 0 && placement_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
